// ===== hdl/sample_block_frame_builder_assert.svh =====
// Assertion macros used by the frame builder back end.
`ifndef SAMPLE_BLOCK_FRAME_BUILDER_ASSERT_SVH
`define SAMPLE_BLOCK_FRAME_BUILDER_ASSERT_SVH

// Condition in the same cycle implies the consequence.
`define SBFB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies the consequence in the next cycle.
`define SBFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sbfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfb_pkg
// Types, constants and the CRC step shared by the frame builder modules.
// ----------------------------------------------------------------------------
package sbfb_pkg;

   localparam logic [7:0] SYNC0_BYTE   = 8'hA5;
   localparam logic [7:0] SYNC1_BYTE   = 8'h5A;
   localparam logic [7:0] VERSION_BYTE = 8'h01;
   localparam logic [7:0] TYPE_BYTE    = 8'h01;
   localparam logic [7:0] CHANNEL_BYTE = 8'h01;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;
   localparam logic [3:0] HDR_LAST_IDX = 4'd14;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [11:0] CODE_FULL   = 12'd4095;
   localparam int unsigned NUM_WIDTH   = 28;

   typedef struct packed {
      logic        hdr;
      logic        last;
      logic [15:0] level_mv;
      logic [31:0] sequence_req;
      logic [15:0] rate;
      logic [15:0] npoints;
   } cmd_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else       c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== hdl/sbfb_front.sv =====
// ----------------------------------------------------------------------------
// sbfb_front
// Accepts samples, tracks the open frame and queues work for the back end.
// ----------------------------------------------------------------------------
module sbfb_front #(
   parameter int BLOCK_POINTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  q_full,
   input  logic [15:0]           req_level_mv,
   input  logic                  req_start_of_block,
   input  logic [31:0]           req_sequence_req,
   input  logic [15:0]           req_rate,
   input  logic [15:0]           req_npoints,
   output logic                  q_push,
   output sbfb_pkg::cmd_type     q_cmd
);

   logic        open_ff, open_in;
   logic [15:0] taken_ff, taken_in;
   logic [15:0] points_ff, points_in;
   logic        accept;
   logic [15:0] clamped;

   assign accept  = push && !q_full;
   assign clamped = (req_npoints > 16'(BLOCK_POINTS)) ? 16'(BLOCK_POINTS)
                                                      : req_npoints;

   always_comb begin
      open_in   = open_ff;
      taken_in  = taken_ff;
      points_in = points_ff;
      q_push    = 1'b0;
      q_cmd.hdr          = req_start_of_block;
      q_cmd.last         = 1'b0;
      q_cmd.level_mv     = req_level_mv;
      q_cmd.sequence_req = req_sequence_req;
      q_cmd.rate         = req_rate;
      q_cmd.npoints      = clamped;
      if (accept) begin
         if (req_start_of_block) begin
            points_in = clamped;
            if (clamped == 16'd0) begin
               open_in  = 1'b0;
               taken_in = 16'd0;
            end else begin
               q_push     = 1'b1;
               taken_in   = 16'd1;
               q_cmd.last = (clamped == 16'd1);
               open_in    = (clamped != 16'd1);
            end
         end else if (open_ff && (taken_ff < points_ff)) begin
            q_push     = 1'b1;
            taken_in   = taken_ff + 16'd1;
            q_cmd.last = (taken_in >= points_ff);
            open_in    = !q_cmd.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         taken_ff  <= 16'd0;
         points_ff <= 16'd0;
      end else begin
         open_ff   <= open_in;
         taken_ff  <= taken_in;
         points_ff <= points_in;
      end
   end

endmodule

// ===== hdl/sbfb_queue.sv =====
// ----------------------------------------------------------------------------
// sbfb_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module sbfb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr,
   input  sbfb_pkg::cmd_type     wdata,
   input  logic                  rd,
   output sbfb_pkg::cmd_type     rdata,
   output logic                  q_full,
   output logic                  q_empty
);

   sbfb_pkg::cmd_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign q_full  = (cnt_ff == 2'd2);
   assign q_empty = (cnt_ff == 2'd0);
   assign rdata   = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end

endmodule

// ===== hdl/sbfb_back.sv =====
// ----------------------------------------------------------------------------
// sbfb_back
// Emits header, converted sample and CRC words through the output register.
// ----------------------------------------------------------------------------
module sbfb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           full_scale_mv,
   input  logic                  q_empty,
   input  sbfb_pkg::cmd_type     q_cmd,
   output logic                  q_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_last_of_frame
);

   typedef enum logic [2:0] {
      IDLE, HDR, DIV, LO, HI, CRCL, CRCH
   } state_type;

   state_type         state_ff;
   sbfb_pkg::cmd_type cmd_ff;
   logic [3:0]        idx_ff;
   logic [4:0]        div_cnt_ff;
   logic [15:0]       rem_ff;
   logic [sbfb_pkg::NUM_WIDTH-1:0] quo_ff;
   logic [15:0]       crc_ff;
   logic              valid_ff;
   logic [7:0]        byte_ff;
   logic              last_ff;

   logic        out_free;
   logic        emit;
   logic [7:0]  emit_byte;
   logic        emit_last;
   logic [7:0]  hdr_byte;
   logic [15:0] conv;
   logic [16:0] trial;
   logic        fits;

   assign out_free          = !valid_ff || pop;
   assign empty             = !valid_ff;
   assign rsp_frame_byte    = byte_ff;
   assign rsp_last_of_frame = last_ff;
   assign q_pop             = (state_ff == IDLE) && !q_empty;

   assign trial = {rem_ff, quo_ff[sbfb_pkg::NUM_WIDTH-1]};
   assign fits  = (trial >= {1'b0, full_scale_mv});

   // A zero full scale and any quotient above 16 bits both saturate.
   assign conv = ((full_scale_mv == 16'd0) || (|quo_ff[sbfb_pkg::NUM_WIDTH-1:16]))
                 ? 16'hFFFF : quo_ff[15:0];

   always_comb begin
      case (idx_ff)
         4'd0:    hdr_byte = sbfb_pkg::SYNC0_BYTE;
         4'd1:    hdr_byte = sbfb_pkg::SYNC1_BYTE;
         4'd2:    hdr_byte = sbfb_pkg::VERSION_BYTE;
         4'd3:    hdr_byte = sbfb_pkg::TYPE_BYTE;
         4'd4:    hdr_byte = cmd_ff.sequence_req[7:0];
         4'd5:    hdr_byte = cmd_ff.sequence_req[15:8];
         4'd6:    hdr_byte = cmd_ff.sequence_req[23:16];
         4'd7:    hdr_byte = cmd_ff.sequence_req[31:24];
         4'd8:    hdr_byte = cmd_ff.rate[7:0];
         4'd9:    hdr_byte = cmd_ff.rate[15:8];
         4'd12:   hdr_byte = sbfb_pkg::CHANNEL_BYTE;
         4'd13:   hdr_byte = cmd_ff.npoints[7:0];
         4'd14:   hdr_byte = cmd_ff.npoints[15:8];
         default: hdr_byte = sbfb_pkg::ZERO_BYTE;
      endcase
   end

   always_comb begin
      emit      = 1'b0;
      emit_byte = hdr_byte;
      emit_last = 1'b0;
      case (state_ff)
         HDR:  emit = out_free;
         LO:   begin emit = out_free; emit_byte = conv[7:0]; end
         HI:   begin emit = out_free; emit_byte = conv[15:8]; end
         CRCL: begin emit = out_free; emit_byte = crc_ff[7:0]; end
         CRCH: begin emit = out_free; emit_byte = crc_ff[15:8]; emit_last = 1'b1; end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
         crc_ff   <= sbfb_pkg::CRC_INIT;
      end else begin
         if (emit) begin
            valid_ff <= 1'b1;
            byte_ff  <= emit_byte;
            last_ff  <= emit_last;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
         // The CRC covers header and sample words, not its own two words.
         if (emit && (state_ff == HDR || state_ff == LO || state_ff == HI)) begin
            crc_ff <= sbfb_pkg::crc_byte(crc_ff, emit_byte);
         end
         case (state_ff)
            IDLE: begin
               if (!q_empty) begin
                  cmd_ff     <= q_cmd;
                  idx_ff     <= 4'd0;
                  div_cnt_ff <= 5'(sbfb_pkg::NUM_WIDTH - 1);
                  rem_ff     <= 16'd0;
                  quo_ff     <= q_cmd.level_mv * sbfb_pkg::CODE_FULL;
                  if (q_cmd.hdr) begin
                     crc_ff   <= sbfb_pkg::CRC_INIT;
                     state_ff <= HDR;
                  end else begin
                     state_ff <= DIV;
                  end
               end
            end
            HDR: begin
               if (emit) begin
                  idx_ff <= idx_ff + 4'd1;
                  if (idx_ff == sbfb_pkg::HDR_LAST_IDX) state_ff <= DIV;
               end
            end
            DIV: begin
               // The remainder stays below the divisor, so 16 bits hold it.
               rem_ff     <= fits ? 16'(trial - {1'b0, full_scale_mv}) : trial[15:0];
               quo_ff     <= {quo_ff[sbfb_pkg::NUM_WIDTH-2:0], fits};
               div_cnt_ff <= div_cnt_ff - 5'd1;
               if (div_cnt_ff == 5'd0) state_ff <= LO;
            end
            LO: if (emit) state_ff <= HI;
            HI: if (emit) state_ff <= cmd_ff.last ? CRCL : IDLE;
            CRCL: if (emit) state_ff <= CRCH;
            CRCH: if (emit) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   `include "sample_block_frame_builder_assert.svh"

   `SBFB_ASSERT_NEXT(a_div_done, clock, reset, state_ff == DIV && div_cnt_ff == 5'd0, state_ff == LO, "divider did not hand over to the low sample word")
   `SBFB_ASSERT_IMPL(a_hdr_idx, clock, reset, state_ff == HDR, idx_ff <= sbfb_pkg::HDR_LAST_IDX, "header index ran past the last header word")
   `SBFB_ASSERT_NEXT(a_crc_init, clock, reset, state_ff == IDLE && !q_empty && q_cmd.hdr, crc_ff == sbfb_pkg::CRC_INIT, "CRC not reinitialized at a new frame")

endmodule

// ===== hdl/sample_block_frame_builder.sv =====
// ----------------------------------------------------------------------------
// sample_block_frame_builder
// Builds framed, CRC-protected byte streams from millivolt samples.
// ----------------------------------------------------------------------------
// Usage: samples enter through push/full with their req_ fields; a sample with
// req_start_of_block opens a frame of min(req_npoints, BLOCK_POINTS) samples.
// Frame words leave through empty/pop; rsp_last_of_frame marks the final CRC
// word. csr_wr_en writes full_scale_mv; the user must write it only while the
// block idles, as the block itself does not enforce it. The first sample of a
// frame is preceded by 15 header words; every sample runs a 28-bit restoring
// divide (one quotient bit per cycle) before its two output words, and the
// closing sample adds two CRC words.
// A two-entry command queue lets the front accept while the back end works.
// When pop is held low the output register holds its word and the back end,
// then the queue, and finally full stall in turn; nothing is lost.
// Reset clears the frame tracking, the queue and the output register, and
// loads full_scale_mv with 3300.
// ----------------------------------------------------------------------------
module sample_block_frame_builder #(
   parameter int BLOCK_POINTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_level_mv,
   input  logic        req_start_of_block,
   input  logic [31:0] req_sequence_req,
   input  logic [15:0] req_rate,
   input  logic [15:0] req_npoints,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_of_frame,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0]       full_scale_ff;
   logic              q_push, q_pop, q_full, q_empty;
   sbfb_pkg::cmd_type w_cmd, r_cmd;

   assign full = q_full;

   always_ff @(posedge clock) begin
      if (reset) full_scale_ff <= 16'd3300;
      else if (csr_wr_en) full_scale_ff <= csr_wr_data;
   end

   sbfb_front #(.BLOCK_POINTS(BLOCK_POINTS)) u_front (
      .clock, .reset, .push, .q_full,
      .req_level_mv, .req_start_of_block, .req_sequence_req,
      .req_rate, .req_npoints,
      .q_push, .q_cmd(w_cmd)
   );

   sbfb_queue u_queue (
      .clock, .reset, .wr(q_push), .wdata(w_cmd), .rd(q_pop), .rdata(r_cmd),
      .q_full, .q_empty
   );

   sbfb_back u_back (
      .clock, .reset, .full_scale_mv(full_scale_ff), .q_empty, .q_cmd(r_cmd),
      .q_pop, .empty, .pop, .rsp_frame_byte, .rsp_last_of_frame
   );

endmodule
